FILE: hw/rtl/sip_pkg.sv
// Shared widths, payload types and side-band struct for the segment intersection point block.
// No dependencies; used by segment_intersection_point.
`default_nettype none

package sip_pkg;

  // coordinate and derived widths
  localparam int unsigned CW   = 24;              // signed Q16.8 coordinate
  localparam int unsigned DW   = CW + 1;          // coordinate difference
  localparam int unsigned MW   = 2 * DW;          // one product of two differences
  localparam int unsigned XW   = MW + 1;          // cross product
  localparam int unsigned LOW  = 26;              // low slice of |num| per partial product
  localparam int unsigned HIW  = XW - LOW;        // high slice of |num|
  localparam int unsigned PW   = DW + XW;         // |dir * num|
  localparam int unsigned QW   = 41;              // quotient bits kept, offset cap is 2^(QW-1)
  localparam int unsigned RW   = PW - QW;         // dividend bits above the quotient window
  localparam int unsigned SW   = QW + 2;          // start plus offset before saturation

  localparam logic signed [CW-1:0] NO_HIT_RESET = CW'(2560000);
  localparam logic [QW-1:0]        OFF_CAP      = QW'(1) << (QW - 1);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [DW-1:0] diff_t;
  typedef logic signed [MW-1:0] prod_t;
  typedef logic signed [XW-1:0] cross_t;

  // per-transaction flags and start point that ride along the divider
  typedef struct packed {
    logic   hit;
    logic   flat;
    logic   ovf_x;
    logic   ovf_y;
    logic   neg_x;
    logic   neg_y;
    coord_t s1x;
    coord_t s1y;
  } side_t;

endpackage

`default_nettype wire

FILE: hw/rtl/segment_intersection_point.sv
// Segment intersection point: fully pipelined hit test and intersection point in Q16.8.
// Depends on sip_pkg for widths, payload types and the side-band struct.
`default_nettype none

// Takes one pair of segments per cycle and returns one result per cycle. The front end
// (differences, 25x25 products, cross products, hit test, split 25x51 product, sum,
// overflow check) takes 7 stages, then a restoring divider produces one quotient bit
// per stage for 41 stages, then one output stage. The whole pipeline advances together
// whenever the output register is empty or not stalled, so in_stall_o is high only
// while a finished result waits and out_stall_i is high. Misses and collinear overlaps
// return no_hit_coordinate on both point outputs; the user must write that register
// through the cfg channel while no transaction is in flight, unenforced by the block.
module segment_intersection_point (
  input  wire                  clk_i,
  input  wire                  rst_ni,
  // configuration
  input  wire                  cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire  sip_pkg::coord_t cfg_no_hit_coordinate_i,
  // input transaction
  input  wire                  in_valid_i,
  output logic                 in_stall_o,
  input  wire  sip_pkg::coord_t first_start_x_i,
  input  wire  sip_pkg::coord_t first_start_y_i,
  input  wire  sip_pkg::coord_t first_end_x_i,
  input  wire  sip_pkg::coord_t first_end_y_i,
  input  wire  sip_pkg::coord_t second_start_x_i,
  input  wire  sip_pkg::coord_t second_start_y_i,
  input  wire  sip_pkg::coord_t second_end_x_i,
  input  wire  sip_pkg::coord_t second_end_y_i,
  // output transaction
  output logic                 out_valid_o,
  input  wire                  out_stall_i,
  output logic                 intersects_o,
  output logic                 collinear_overlap_o,
  output sip_pkg::coord_t      point_x_o,
  output sip_pkg::coord_t      point_y_o
);
  import sip_pkg::*;

  logic   adv;
  coord_t no_hit_q;

  // pipeline moves as one when the output slot is free or being taken
  assign adv         = !out_valid_o || !out_stall_i;
  assign in_stall_o  = !adv;
  assign cfg_ready_o = 1'b1;

  // sentinel register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      no_hit_q <= NO_HIT_RESET;
    end else if (cfg_valid_i) begin
      no_hit_q <= cfg_no_hit_coordinate_i;
    end
  end

  // ---------------- stage 1: differences, quirk and bounding box ----------------
  logic   ok_d;
  coord_t min1x, max1x, min1y, max1y, min2x, max2x, min2y, max2y;

  always_comb begin
    min1x = (first_start_x_i < first_end_x_i) ? first_start_x_i : first_end_x_i;
    max1x = (first_start_x_i > first_end_x_i) ? first_start_x_i : first_end_x_i;
    min1y = (first_start_y_i < first_end_y_i) ? first_start_y_i : first_end_y_i;
    max1y = (first_start_y_i > first_end_y_i) ? first_start_y_i : first_end_y_i;
    min2x = (second_start_x_i < second_end_x_i) ? second_start_x_i : second_end_x_i;
    max2x = (second_start_x_i > second_end_x_i) ? second_start_x_i : second_end_x_i;
    min2y = (second_start_y_i < second_end_y_i) ? second_start_y_i : second_end_y_i;
    max2y = (second_start_y_i > second_end_y_i) ? second_start_y_i : second_end_y_i;
    ok_d  = 1'b1;
    // both vertical on one x, or both horizontal on one y
    if ((first_start_x_i == first_end_x_i && first_end_x_i == second_start_x_i &&
         second_start_x_i == second_end_x_i) ||
        (first_start_y_i == first_end_y_i && first_end_y_i == second_start_y_i &&
         second_start_y_i == second_end_y_i)) begin
      ok_d = 1'b0;
    end
    if (max2x < min1x || max2y < min1y || max1x < min2x || max1y < min2y) begin
      ok_d = 1'b0;
    end
  end

  logic   v1_q, ok1_q;
  coord_t s1x1_q, s1y1_q;
  diff_t  d1x_q, d1y_q, d2x_q, d2y_q, ux_q, uy_q, vx_q, vy_q;
  diff_t  wx_q, wy_q, zx_q, zy_q, bx_q, by_q, mx_q, my_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else if (adv) begin
      v1_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok1_q  <= ok_d;
      s1x1_q <= first_start_x_i;
      s1y1_q <= first_start_y_i;
      d1x_q  <= diff_t'(first_end_x_i) - diff_t'(first_start_x_i);
      d1y_q  <= diff_t'(first_end_y_i) - diff_t'(first_start_y_i);
      d2x_q  <= diff_t'(second_end_x_i) - diff_t'(second_start_x_i);
      d2y_q  <= diff_t'(second_end_y_i) - diff_t'(second_start_y_i);
      ux_q   <= diff_t'(first_start_x_i) - diff_t'(second_start_x_i);
      uy_q   <= diff_t'(first_start_y_i) - diff_t'(second_start_y_i);
      vx_q   <= diff_t'(first_end_x_i) - diff_t'(second_start_x_i);
      vy_q   <= diff_t'(first_end_y_i) - diff_t'(second_start_y_i);
      wx_q   <= diff_t'(second_start_x_i) - diff_t'(first_end_x_i);
      wy_q   <= diff_t'(second_start_y_i) - diff_t'(first_end_y_i);
      zx_q   <= diff_t'(second_end_x_i) - diff_t'(first_end_x_i);
      zy_q   <= diff_t'(second_end_y_i) - diff_t'(first_end_y_i);
      bx_q   <= diff_t'(first_start_x_i) - diff_t'(first_end_x_i);
      by_q   <= diff_t'(first_start_y_i) - diff_t'(first_end_y_i);
      mx_q   <= diff_t'(second_start_x_i) - diff_t'(first_start_x_i);
      my_q   <= diff_t'(second_start_y_i) - diff_t'(first_start_y_i);
    end
  end

  // ---------------- stage 2: cross product terms ----------------
  logic   v2_q, ok2_q;
  coord_t s1x2_q, s1y2_q;
  diff_t  d1x2_q, d1y2_q;
  prod_t  c1a_q, c1b_q, c2a_q, c2b_q, c3a_q, c3b_q, c4a_q, c4b_q;
  prod_t  dna_q, dnb_q, nma_q, nmb_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else if (adv) begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok2_q  <= ok1_q;
      s1x2_q <= s1x1_q;
      s1y2_q <= s1y1_q;
      d1x2_q <= d1x_q;
      d1y2_q <= d1y_q;
      c1a_q  <= ux_q * d2y_q;
      c1b_q  <= d2x_q * uy_q;
      c2a_q  <= vx_q * d2y_q;
      c2b_q  <= d2x_q * vy_q;
      c3a_q  <= wx_q * by_q;
      c3b_q  <= bx_q * wy_q;
      c4a_q  <= zx_q * by_q;
      c4b_q  <= bx_q * zy_q;
      dna_q  <= d1x_q * d2y_q;
      dnb_q  <= d2x_q * d1y_q;
      nma_q  <= mx_q * d2y_q;
      nmb_q  <= d2x_q * my_q;
    end
  end

  // ---------------- stage 3: cross products ----------------
  logic   v3_q, ok3_q;
  coord_t s1x3_q, s1y3_q;
  diff_t  d1x3_q, d1y3_q;
  cross_t c1_q, c2_q, c3_q, c4_q, den_q, num_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else if (adv) begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ok3_q  <= ok2_q;
      s1x3_q <= s1x2_q;
      s1y3_q <= s1y2_q;
      d1x3_q <= d1x2_q;
      d1y3_q <= d1y2_q;
      c1_q   <= cross_t'(c1a_q) - cross_t'(c1b_q);
      c2_q   <= cross_t'(c2a_q) - cross_t'(c2b_q);
      c3_q   <= cross_t'(c3a_q) - cross_t'(c3b_q);
      c4_q   <= cross_t'(c4a_q) - cross_t'(c4b_q);
      den_q  <= cross_t'(dna_q) - cross_t'(dnb_q);
      num_q  <= cross_t'(nma_q) - cross_t'(nmb_q);
    end
  end

  // ---------------- stage 4: straddle test and magnitudes ----------------
  logic straddle_a, straddle_b;
  assign straddle_a = (c1_q == '0) || (c2_q == '0) || (c1_q[XW-1] ^ c2_q[XW-1]);
  assign straddle_b = (c3_q == '0) || (c4_q == '0) || (c3_q[XW-1] ^ c4_q[XW-1]);

  logic          v4_q, hit4_q, flat4_q, negx4_q, negy4_q;
  coord_t        s1x4_q, s1y4_q;
  logic [DW-1:0] dxm_q, dym_q;
  logic [XW-1:0] numm_q, denm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v4_q <= 1'b0;
    end else if (adv) begin
      v4_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      hit4_q  <= ok3_q && straddle_a && straddle_b;
      flat4_q <= (den_q == '0);
      negx4_q <= d1x3_q[DW-1] ^ num_q[XW-1] ^ den_q[XW-1];
      negy4_q <= d1y3_q[DW-1] ^ num_q[XW-1] ^ den_q[XW-1];
      s1x4_q  <= s1x3_q;
      s1y4_q  <= s1y3_q;
      dxm_q   <= d1x3_q[DW-1] ? DW'(-d1x3_q) : DW'(d1x3_q);
      dym_q   <= d1y3_q[DW-1] ? DW'(-d1y3_q) : DW'(d1y3_q);
      numm_q  <= num_q[XW-1] ? XW'(-num_q) : XW'(num_q);
      denm_q  <= den_q[XW-1] ? XW'(-den_q) : XW'(den_q);
    end
  end

  // ---------------- stage 5: split products dir * num ----------------
  logic              v5_q;
  side_t             sd5_q;
  logic [XW-1:0]     den5_q;
  logic [DW+LOW-1:0] pxl_q, pyl_q;
  logic [DW+HIW-1:0] pxh_q, pyh_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v5_q <= 1'b0;
    end else if (adv) begin
      v5_q <= v4_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd5_q.hit   <= hit4_q;
      sd5_q.flat  <= flat4_q;
      sd5_q.ovf_x <= 1'b0;
      sd5_q.ovf_y <= 1'b0;
      sd5_q.neg_x <= negx4_q;
      sd5_q.neg_y <= negy4_q;
      sd5_q.s1x   <= s1x4_q;
      sd5_q.s1y   <= s1y4_q;
      den5_q      <= denm_q;
      pxl_q       <= (DW+LOW)'(dxm_q) * (DW+LOW)'(numm_q[LOW-1:0]);
      pyl_q       <= (DW+LOW)'(dym_q) * (DW+LOW)'(numm_q[LOW-1:0]);
      pxh_q       <= (DW+HIW)'(dxm_q) * (DW+HIW)'(numm_q[XW-1:LOW]);
      pyh_q       <= (DW+HIW)'(dym_q) * (DW+HIW)'(numm_q[XW-1:LOW]);
    end
  end

  // ---------------- stage 6: full dividend ----------------
  logic          v6_q;
  side_t         sd6_q;
  logic [XW-1:0] den6_q;
  logic [PW-1:0] nx_q, ny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v6_q <= 1'b0;
    end else if (adv) begin
      v6_q <= v5_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd6_q  <= sd5_q;
      den6_q <= den5_q;
      nx_q   <= PW'(pxl_q) + (PW'(pxh_q) << LOW);
      ny_q   <= PW'(pyl_q) + (PW'(pyh_q) << LOW);
    end
  end

  // ---------------- stage 7: quotient overflow and divider seed ----------------
  logic          v_q   [QW+1];
  side_t         sd_q  [QW+1];
  logic [XW-1:0] dd_q  [QW+1];
  logic [XW-1:0] rx_q  [QW+1];
  logic [XW-1:0] ry_q  [QW+1];
  logic [QW-1:0] qx_q  [QW+1];
  logic [QW-1:0] qy_q  [QW+1];
  side_t         sd7_d;

  // side band with the quotient overflow flags filled in
  always_comb begin
    sd7_d       = sd6_q;
    sd7_d.ovf_x = XW'(nx_q[PW-1:QW]) >= den6_q;
    sd7_d.ovf_y = XW'(ny_q[PW-1:QW]) >= den6_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (adv) begin
      v_q[0] <= v6_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      sd_q[0]       <= sd7_d;
      dd_q[0]       <= den6_q;
      rx_q[0]       <= XW'(nx_q[PW-1:QW]);
      ry_q[0]       <= XW'(ny_q[PW-1:QW]);
      qx_q[0]       <= nx_q[QW-1:0];
      qy_q[0]       <= ny_q[QW-1:0];
    end
  end

  // ---------------- divider: one quotient bit per stage ----------------
  for (genvar k = 0; k < QW; k++) begin : g_div
    logic [XW:0] prex, prey;
    logic        gex, gey;

    assign prex = {rx_q[k], qx_q[k][QW-1]};
    assign prey = {ry_q[k], qy_q[k][QW-1]};
    assign gex  = prex >= {1'b0, dd_q[k]};
    assign gey  = prey >= {1'b0, dd_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k+1] <= 1'b0;
      end else if (adv) begin
        v_q[k+1] <= v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        sd_q[k+1] <= sd_q[k];
        dd_q[k+1] <= dd_q[k];
        rx_q[k+1] <= gex ? XW'(prex - {1'b0, dd_q[k]}) : XW'(prex);
        ry_q[k+1] <= gey ? XW'(prey - {1'b0, dd_q[k]}) : XW'(prey);
        qx_q[k+1] <= {qx_q[k][QW-2:0], gex};
        qy_q[k+1] <= {qy_q[k][QW-2:0], gey};
      end
    end
  end

  // ---------------- output: cap, sign, add start, saturate ----------------
  side_t         sdf;
  logic [QW-1:0] magx, magy;
  logic [SW-1:0] sumx, sumy;
  coord_t        ptx, pty;
  logic signed [SW-1:0] cmax, cmin;

  assign sdf  = sd_q[QW];
  assign cmax = SW'(coord_t'({1'b0, {(CW-1){1'b1}}}));
  assign cmin = SW'(coord_t'({1'b1, {(CW-1){1'b0}}}));

  always_comb begin
    magx = (sdf.ovf_x || qx_q[QW] > OFF_CAP) ? OFF_CAP : qx_q[QW];
    magy = (sdf.ovf_y || qy_q[QW] > OFF_CAP) ? OFF_CAP : qy_q[QW];
    sumx = SW'(sdf.s1x) + (sdf.neg_x ? -SW'(magx) : SW'(magx));
    sumy = SW'(sdf.s1y) + (sdf.neg_y ? -SW'(magy) : SW'(magy));
    ptx  = (signed'(sumx) > cmax) ? CW'(cmax) :
           (signed'(sumx) < cmin) ? CW'(cmin) : CW'(sumx);
    pty  = (signed'(sumy) > cmax) ? CW'(cmax) :
           (signed'(sumy) < cmin) ? CW'(cmin) : CW'(sumy);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (adv) begin
      out_valid_o <= v_q[QW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      intersects_o        <= sdf.hit;
      collinear_overlap_o <= sdf.hit && sdf.flat;
      point_x_o           <= (sdf.hit && !sdf.flat) ? ptx : no_hit_q;
      point_y_o           <= (sdf.hit && !sdf.flat) ? pty : no_hit_q;
    end
  end

endmodule

`default_nettype wire
